// File: rtl/imbr_pkg.sv
// Shared constants and types for the inverse map bilinear resampler.
package imbr_pkg;

    // Default sizes of the frame store and the fraction width
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 12;

    // Fixed field widths
    localparam int POS_W   = 10;
    localparam int COEF_W  = 16;
    localparam int SIZE_W  = 9;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    // coef * (col or row) and the sum of two such terms
    localparam int PROD_W  = COEF_W + POS_W + 1;
    localparam int SUM_W   = PROD_W + 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH    = 3'd0,
        CFG_SOURCE_HEIGHT   = 3'd1,
        CFG_COEF_X_FROM_COL = 3'd2,
        CFG_COEF_X_FROM_ROW = 3'd3,
        CFG_COEF_Y_FROM_COL = 3'd4,
        CFG_COEF_Y_FROM_ROW = 3'd5,
        CFG_FILL_VALUE      = 3'd6
    } cfg_idx_t;

    // Input actions
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Register reset values
    localparam logic [SIZE_W-1:0] SIZE_RST  = 9'd256;
    localparam logic [COEF_W-1:0] COEF_ONE  = 16'd4096;
    localparam logic [COEF_W-1:0] COEF_ZERO = 16'd0;
    localparam logic [CHAN_W-1:0] FILL_RST  = 8'd255;

endpackage

// File: rtl/inverse_map_bilinear_resampler_top.sv
// Top level of the inverse map bilinear resampler: frame store and sample pipeline.
//
//  channel | ports             | direction | content
//  --------+-------------------+-----------+---------------------------------------------
//  input   | s_tvalid/s_tready | in        | s_tdata: pos_row,pos_col,red,green,blue; s_tuser: action
//  result  | m_tvalid/m_tready | out       | m_tdata: out_red,out_green,out_blue; m_tuser: in_range
//  config  | cfg_valid/ready   | in        | cfg_addr register index, cfg_data value
//
// One request enters per clock while no result is stalled; a sample result leaves from the final stage register.
// The frame store is four banks split by row and column parity, so the four
// neighbors are read together; a write lands in the same stage as sample reads.
// aresetn clears valid bits and config registers; frame store content is undefined.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module inverse_map_bilinear_resampler_top #(
    parameter int MAX_WIDTH  = imbr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = imbr_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = imbr_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_row[9:0], pos_col[19:10], red, green, blue, zero pad
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic        m_tuser,   // in_range
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [imbr_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [imbr_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int F      = FRAC_BITS;
    localparam int QW     = imbr_pkg::PROD_W - F;       // integer part of a mapped coordinate
    localparam int BW     = (MAX_WIDTH + 1) / 2;        // bank columns
    localparam int BH     = (MAX_HEIGHT + 1) / 2;       // bank rows
    localparam int DEPTH  = BW * BH;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW     = $clog2(MAX_WIDTH + 1);
    localparam int DH     = $clog2(MAX_HEIGHT + 1);
    localparam int WW     = 2 * F + 2;                  // bilinear weight
    localparam int CPW    = WW + imbr_pkg::CHAN_W;      // weight * channel
    localparam int ACC_W  = CPW + 2;
    localparam int CW     = imbr_pkg::CHAN_W;
    localparam int PW     = imbr_pkg::POS_W;

    logic en;

    // Configuration registers
    logic [imbr_pkg::SIZE_W-1:0]        src_w_reg, src_h_reg;
    logic signed [imbr_pkg::COEF_W-1:0] cxc_reg, cxr_reg, cyc_reg, cyr_reg;
    logic [CW-1:0]                      fill_reg;
    logic [DW-1:0]                      w_eff;
    logic [DH-1:0]                      h_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= imbr_pkg::SIZE_RST;
            src_h_reg <= imbr_pkg::SIZE_RST;
            cxc_reg   <= imbr_pkg::COEF_ONE;
            cxr_reg   <= imbr_pkg::COEF_ZERO;
            cyc_reg   <= imbr_pkg::COEF_ZERO;
            cyr_reg   <= imbr_pkg::COEF_ONE;
            fill_reg  <= imbr_pkg::FILL_RST;
        end else if (cfg_valid) begin
            case (imbr_pkg::cfg_idx_t'(cfg_addr))
                imbr_pkg::CFG_SOURCE_WIDTH:    src_w_reg <= cfg_data[imbr_pkg::SIZE_W-1:0];
                imbr_pkg::CFG_SOURCE_HEIGHT:   src_h_reg <= cfg_data[imbr_pkg::SIZE_W-1:0];
                imbr_pkg::CFG_COEF_X_FROM_COL: cxc_reg <= cfg_data;
                imbr_pkg::CFG_COEF_X_FROM_ROW: cxr_reg <= cfg_data;
                imbr_pkg::CFG_COEF_Y_FROM_COL: cyc_reg <= cfg_data;
                imbr_pkg::CFG_COEF_Y_FROM_ROW: cyr_reg <= cfg_data;
                imbr_pkg::CFG_FILL_VALUE:      fill_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero reads as one, above the store size reads as the maximum
    always_comb begin
        if (src_w_reg == '0)
            w_eff = DW'(1);
        else if (32'(src_w_reg) > MAX_WIDTH)
            w_eff = DW'(MAX_WIDTH);
        else
            w_eff = DW'(src_w_reg);
        if (src_h_reg == '0)
            h_eff = DH'(1);
        else if (32'(src_h_reg) > MAX_HEIGHT)
            h_eff = DH'(MAX_HEIGHT);
        else
            h_eff = DH'(src_h_reg);
    end

    // Pipeline advance: hold everything while a result waits
    assign en       = !(m_tvalid && !m_tready);
    assign s_tready = en;

    // Stage 1: input capture
    logic                     v1_reg, act1_reg;
    logic [PW-1:0]            row1_reg, col1_reg;
    logic [imbr_pkg::PIX_W-1:0] pix1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act1_reg <= s_tuser;
            row1_reg <= s_tdata[9:0];
            col1_reg <= s_tdata[19:10];
            pix1_reg <= s_tdata[43:20];
        end
    end

    // Stage 2: coefficient products
    logic                     v2_reg, act2_reg;
    logic [PW-1:0]            row2_reg, col2_reg;
    logic [imbr_pkg::PIX_W-1:0] pix2_reg;
    logic signed [imbr_pkg::PROD_W-1:0] pxc_reg, pxr_reg, pyc_reg, pyr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act2_reg <= act1_reg;
            row2_reg <= row1_reg;
            col2_reg <= col1_reg;
            pix2_reg <= pix1_reg;
            pxc_reg  <= cxc_reg * $signed({1'b0, col1_reg});
            pxr_reg  <= cxr_reg * $signed({1'b0, row1_reg});
            pyc_reg  <= cyc_reg * $signed({1'b0, col1_reg});
            pyr_reg  <= cyr_reg * $signed({1'b0, row1_reg});
        end
    end

    // Stage 3: mapped point, range check, integer and fraction split
    logic signed [imbr_pkg::SUM_W-1:0] x_s, y_s;
    logic [QW-1:0]  q_s, p_s;
    logic           inr_s, nb_s;

    assign x_s = imbr_pkg::SUM_W'(pxc_reg) + imbr_pkg::SUM_W'(pxr_reg);
    assign y_s = imbr_pkg::SUM_W'(pyc_reg) + imbr_pkg::SUM_W'(pyr_reg);
    assign q_s = x_s[imbr_pkg::PROD_W-1:F];
    assign p_s = y_s[imbr_pkg::PROD_W-1:F];

    always_comb begin
        inr_s = !x_s[imbr_pkg::SUM_W-1] && !y_s[imbr_pkg::SUM_W-1]
                && (32'(q_s) < 32'(w_eff)) && (32'(p_s) < 32'(h_eff));
        nb_s  = (32'(q_s) + 32'd1 < 32'(w_eff)) && (32'(p_s) + 32'd1 < 32'(h_eff));
    end

    logic                     v3_reg, act3_reg, inr3_reg, nb3_reg;
    logic [PW-1:0]            row3_reg, col3_reg;
    logic [imbr_pkg::PIX_W-1:0] pix3_reg;
    logic [QW-1:0]            q3_reg, p3_reg;
    logic [F-1:0]             fx3_reg, fy3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act3_reg <= act2_reg;
            row3_reg <= row2_reg;
            col3_reg <= col2_reg;
            pix3_reg <= pix2_reg;
            inr3_reg <= inr_s;
            nb3_reg  <= nb_s;
            q3_reg   <= q_s;
            p3_reg   <= p_s;
            fx3_reg  <= x_s[F-1:0];
            fy3_reg  <= y_s[F-1:0];
        end
    end

    // Frame store banks, index {row parity, column parity}
    logic [AW-1:0]  raddr [4];
    logic [AW-1:0]  waddr;
    logic [1:0]     wbank;
    logic           wr_en;
    logic [imbr_pkg::PIX_W-1:0] rd_word [4];

    always_comb begin
        logic [31:0] rr, cc;
        rr = '0;
        cc = '0;
        for (int b = 0; b < 4; b++) begin
            // pick p or p+1, q or q+1, whichever has this bank's parity
            rr = 32'(p3_reg) + ((p3_reg[0] != b[1]) ? 32'd1 : 32'd0);
            cc = 32'(q3_reg) + ((q3_reg[0] != b[0]) ? 32'd1 : 32'd0);
            raddr[b] = AW'((rr >> 1) * BW + (cc >> 1));
        end
    end

    always_comb begin
        waddr = AW'((32'(row3_reg) >> 1) * BW + (32'(col3_reg) >> 1));
        wbank = {row3_reg[0], col3_reg[0]};
        wr_en = en && v3_reg && (act3_reg == imbr_pkg::ACT_WRITE)
                && (32'(row3_reg) < MAX_HEIGHT) && (32'(col3_reg) < MAX_WIDTH);
    end

    // One memory per bank, one write port and one registered read port each
    for (genvar gb = 0; gb < 4; gb++) begin : g_bank
        logic [imbr_pkg::PIX_W-1:0] bank_mem [DEPTH];
        logic [imbr_pkg::PIX_W-1:0] rd_reg;

        always_ff @(posedge aclk) begin
            if (wr_en && (wbank == 2'(gb)))
                bank_mem[waddr] <= pix3_reg;
        end

        always_ff @(posedge aclk) begin
            if (en)
                rd_reg <= bank_mem[raddr[gb]];
        end

        assign rd_word[gb] = rd_reg;
    end

    // Stage 4: bilinear weights, alongside the bank reads
    logic [F:0]     ofx, ofy;
    logic           v4_reg, smp4_reg, inr4_reg, nb4_reg, p04_reg, q04_reg;
    logic [WW-1:0]  w1_reg, w2_reg, w3_reg, w4_reg;

    assign ofx = (F+1)'(1 << F) - {1'b0, fx3_reg};
    assign ofy = (F+1)'(1 << F) - {1'b0, fy3_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            smp4_reg <= (act3_reg == imbr_pkg::ACT_SAMPLE);
            inr4_reg <= inr3_reg;
            nb4_reg  <= nb3_reg;
            p04_reg  <= p3_reg[0];
            q04_reg  <= q3_reg[0];
            w1_reg   <= WW'(ofx) * WW'(ofy);
            w2_reg   <= WW'(fx3_reg) * WW'(ofy);
            w3_reg   <= WW'(ofx) * WW'(fy3_reg);
            w4_reg   <= WW'(fx3_reg) * WW'(fy3_reg);
        end
    end

    // Neighbors from banks: A (p,q), B (p,q+1), C (p+1,q), D (p+1,q+1)
    logic [imbr_pkg::PIX_W-1:0] nbr [4];
    always_comb begin
        nbr[0] = rd_word[{p04_reg,  q04_reg}];
        nbr[1] = rd_word[{p04_reg, !q04_reg}];
        nbr[2] = rd_word[{!p04_reg,  q04_reg}];
        nbr[3] = rd_word[{!p04_reg, !q04_reg}];
    end

    // Stage 5: weight times channel products
    logic                     v5_reg, smp5_reg, inr5_reg, nb5_reg;
    logic [imbr_pkg::PIX_W-1:0] a5_reg;
    logic [CPW-1:0]           cp5_reg [3][4];
    logic [WW-1:0]            wsel [4];

    assign wsel[0] = w1_reg;
    assign wsel[1] = w2_reg;
    assign wsel[2] = w3_reg;
    assign wsel[3] = w4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            smp5_reg <= smp4_reg;
            inr5_reg <= inr4_reg;
            nb5_reg  <= nb4_reg;
            a5_reg   <= nbr[0];
            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 4; j++)
                    cp5_reg[k][j] <= CPW'(wsel[j]) * CPW'(nbr[j][k*CW +: CW]);
        end
    end

    // Stage 6: sum, truncate, select neighbor A or fill
    logic [ACC_W-1:0] acc [3];
    logic [imbr_pkg::PIX_W-1:0] res_next;
    logic [imbr_pkg::PIX_W-1:0] res_reg;
    logic             inr6_reg, v6_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc[k] = ACC_W'(cp5_reg[k][0]) + ACC_W'(cp5_reg[k][1])
                   + ACC_W'(cp5_reg[k][2]) + ACC_W'(cp5_reg[k][3]);
            if (!inr5_reg)
                res_next[k*CW +: CW] = fill_reg;
            else if (nb5_reg)
                res_next[k*CW +: CW] = acc[k][2*F +: CW];
            else
                res_next[k*CW +: CW] = a5_reg[k*CW +: CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= v5_reg && smp5_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg  <= res_next;
            inr6_reg <= inr5_reg;
        end
    end

    assign m_tvalid = v6_reg;
    assign m_tdata  = res_reg;
    assign m_tuser  = inr6_reg;

endmodule

// File: rtl/imbr_checker.sv
// Port-level checker for the resampler top, bound to it.
module imbr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // A waiting result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result freezes the pipeline input
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken during output stall");

    // Out of range results carry the same fill on every channel
    a_fill_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[7:0] == m_tdata[15:8])
                                 && (m_tdata[7:0] == m_tdata[23:16]))
        else $error("fill channels differ");

    // Nothing comes out right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result after reset");

endmodule

bind inverse_map_bilinear_resampler_top imbr_checker u_imbr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/inverse_map_bilinear_resampler_top_tb.sv
// Self-checking testbench for the inverse map bilinear resampler top level.
`timescale 1ns / 1ps

module inverse_map_bilinear_resampler_top_tb;

    localparam int FRAC       = imbr_pkg::FRAC_BITS_DEF;
    localparam int STORE_W    = imbr_pkg::MAX_WIDTH_DEF;
    localparam int STORE_H    = imbr_pkg::MAX_HEIGHT_DEF;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 20;
    localparam int HOLD_LEN   = 300;
    localparam logic [imbr_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    // Expected result of one sample request
    typedef struct packed {
        logic [imbr_pkg::CHAN_W-1:0] red;
        logic [imbr_pkg::CHAN_W-1:0] green;
        logic [imbr_pkg::CHAN_W-1:0] blue;
        logic                        in_range;
    } pixel_result_t;

    // One row of the directed stimulus table
    typedef struct {
        logic        action;
        int          row;
        int          col;
        int          red;
        int          green;
        int          blue;
        bit          typed;
        int          exp_red;
        int          exp_green;
        int          exp_blue;
        bit          exp_in_range;
    } directed_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // pos_row[9:0], pos_col[19:10], red, green, blue, zero pad
    logic        s_tuser = 1'b0; // action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // out_red[7:0], out_green[15:8], out_blue[23:16]
    logic        m_tuser;        // in_range
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [imbr_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [imbr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow of the block: registers, frame store and written marks
    int unsigned                  src_width;
    int unsigned                  src_height;
    int                           cx_col, cx_row, cy_col, cy_row;
    logic [imbr_pkg::CHAN_W-1:0]  fill_shadow;
    logic [imbr_pkg::PIX_W-1:0]   store_shadow [STORE_W*STORE_H];
    bit                           store_written [STORE_W*STORE_H];

    pixel_result_t pending_pixels [$];
    int  fail_count = 0;
    int  cycle_count = 0;
    int  gap_pct = 0;
    int  stall_pct = 0;
    logic rx_hold = 1'b0;
    bit  hold_start = 1'b0;

    directed_req_t directed_rows [13] = '{
        '{imbr_pkg::ACT_WRITE,  0,    0,    0,   0,   0,   0, 0, 0, 0, 0},
        '{imbr_pkg::ACT_WRITE,  0,    1,    255, 255, 255, 0, 0, 0, 0, 0},
        '{imbr_pkg::ACT_WRITE,  1,    0,    255, 0,   0,   0, 0, 0, 0, 0},
        '{imbr_pkg::ACT_WRITE,  1,    1,    0,   255, 255, 0, 0, 0, 0, 0},
        '{imbr_pkg::ACT_WRITE,  255,  255,  18,  52,  86,  0, 0, 0, 0, 0},
        '{imbr_pkg::ACT_WRITE,  1023, 5,    9,   9,   9,   0, 0, 0, 0, 0},
        '{imbr_pkg::ACT_WRITE,  3,    1023, 7,   7,   7,   0, 0, 0, 0, 0},
        '{imbr_pkg::ACT_SAMPLE, 0,    0,    0,   0,   0,   1, 0,   0,   0,   1},
        '{imbr_pkg::ACT_SAMPLE, 255,  255,  0,   0,   0,   1, 18,  52,  86,  1},
        '{imbr_pkg::ACT_SAMPLE, 256,  0,    0,   0,   0,   1, 255, 255, 255, 0},
        '{imbr_pkg::ACT_SAMPLE, 0,    256,  0,   0,   0,   1, 255, 255, 255, 0},
        '{imbr_pkg::ACT_SAMPLE, 1023, 1023, 0,   0,   0,   1, 255, 255, 255, 0},
        '{imbr_pkg::ACT_SAMPLE, 0,    0,    255, 255, 255, 1, 0,   0,   0,   1}
    };

    inverse_map_bilinear_resampler_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("inverse_map_bilinear_resampler_top regression: fail");
            $finish;
        end
    end

    // Long receiver hold-off, started once by the stimulus
    initial begin
        wait (hold_start);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Result side: check each result, then pick next ready
    always @(posedge aclk) begin
        pixel_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected result %h in_range %b", m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (m_tdata[7:0] !== want.red) begin
                    $error("out_red exp %0d got %0d", want.red, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[15:8] !== want.green) begin
                    $error("out_green exp %0d got %0d", want.green, m_tdata[15:8]);
                    fail_count++;
                end
                if (m_tdata[23:16] !== want.blue) begin
                    $error("out_blue exp %0d got %0d", want.blue, m_tdata[23:16]);
                    fail_count++;
                end
                if (m_tuser !== want.in_range) begin
                    $error("in_range exp %0d got %0d", want.in_range, m_tuser);
                    fail_count++;
                end
            end
        end
        m_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    // Map a destination point back into the source; report position and fractions
    function automatic bit map_back(input int row, input int col, output int p, output int q,
                                    output int fx, output int fy, output bit four);
        int x;
        int y;
        int unsigned w;
        int unsigned h;
        w = clamp_size(src_width, STORE_W);
        h = clamp_size(src_height, STORE_H);
        x = cx_col * col + cx_row * row;
        y = cy_col * col + cy_row * row;
        q = x >>> FRAC;
        p = y >>> FRAC;
        fx = x & ((1 << FRAC) - 1);
        fy = y & ((1 << FRAC) - 1);
        four = (p + 1 < h) && (q + 1 < w);
        return !(x < 0 || y < 0 || x >= (w << FRAC) || y >= (h << FRAC));
    endfunction

    // Bilinear result for a sample request
    function automatic pixel_result_t resample(input int row, input int col);
        pixel_result_t res;
        int p, q, fx, fy;
        bit four;
        longint one;
        longint wa, wb, wc, wd, acc;
        logic [imbr_pkg::PIX_W-1:0] a, b, c, d;
        if (!map_back(row, col, p, q, fx, fy, four)) begin
            res = '{fill_shadow, fill_shadow, fill_shadow, 1'b0};
            return res;
        end
        a = store_shadow[p*STORE_W + q];
        res.in_range = 1'b1;
        if (!four) begin
            res.red = a[7:0];
            res.green = a[15:8];
            res.blue = a[23:16];
            return res;
        end
        b = store_shadow[p*STORE_W + q + 1];
        c = store_shadow[(p+1)*STORE_W + q];
        d = store_shadow[(p+1)*STORE_W + q + 1];
        one = 1 << FRAC;
        wa = (one - fx) * (one - fy);
        wb = fx * (one - fy);
        wc = (one - fx) * fy;
        wd = longint'(fx) * fy;
        for (int k = 0; k < 3; k++) begin
            acc = wa * a[8*k +: 8] + wb * b[8*k +: 8] + wc * c[8*k +: 8] + wd * d[8*k +: 8];
            case (k)
                0: res.red = 8'(acc >> (2*FRAC));
                1: res.green = 8'(acc >> (2*FRAC));
                default: res.blue = 8'(acc >> (2*FRAC));
            endcase
        end
        return res;
    endfunction

    // Offer one request and wait for it; update the shadow at acceptance
    task automatic send_request(input logic act, input int row, input int col,
                                input int r, input int g, input int b,
                                input bit typed, input pixel_result_t typed_res);
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < gap_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'h0, b[7:0], g[7:0], r[7:0], col[9:0], row[9:0]};
        do @(posedge aclk); while (!s_tready);
        if (act == imbr_pkg::ACT_WRITE) begin
            if (row < STORE_H && col < STORE_W) begin
                store_shadow[row*STORE_W + col] = {b[7:0], g[7:0], r[7:0]};
                store_written[row*STORE_W + col] = 1'b1;
            end
        end else begin
            pending_pixels.push_back(typed ? typed_res : resample(row, col));
        end
    endtask

    task automatic end_requests();
        s_tvalid <= 1'b0;
    endtask

    // Wait until every result is back and the pipeline has gone quiet
    task automatic drain();
        end_requests();
        @(posedge aclk);
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [imbr_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= value[15:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            imbr_pkg::CFG_SOURCE_WIDTH:    src_width = value & 9'h1FF;
            imbr_pkg::CFG_SOURCE_HEIGHT:   src_height = value & 9'h1FF;
            imbr_pkg::CFG_COEF_X_FROM_COL: cx_col = 32'(signed'(value[15:0]));
            imbr_pkg::CFG_COEF_X_FROM_ROW: cx_row = 32'(signed'(value[15:0]));
            imbr_pkg::CFG_COEF_Y_FROM_COL: cy_col = 32'(signed'(value[15:0]));
            imbr_pkg::CFG_COEF_Y_FROM_ROW: cy_row = 32'(signed'(value[15:0]));
            imbr_pkg::CFG_FILL_VALUE:      fill_shadow = value[7:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input int w, input int h, input int cxc, input int cxr,
                                 input int cyc, input int cyr, input int fill);
        write_reg(imbr_pkg::CFG_SOURCE_WIDTH, w);
        write_reg(imbr_pkg::CFG_SOURCE_HEIGHT, h);
        write_reg(imbr_pkg::CFG_COEF_X_FROM_COL, cxc);
        write_reg(imbr_pkg::CFG_COEF_X_FROM_ROW, cxr);
        write_reg(imbr_pkg::CFG_COEF_Y_FROM_COL, cyc);
        write_reg(imbr_pkg::CFG_COEF_Y_FROM_ROW, cyr);
        write_reg(imbr_pkg::CFG_FILL_VALUE, fill);
    endtask

    // Fill the corner of the source, then mix samples with writes
    task automatic random_traffic(input int count);
        int row, col, p, q, fx, fy, addr;
        bit four, hit, missing;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                send_request(imbr_pkg::ACT_WRITE, r, c, $urandom_range(255),
                             $urandom_range(255), $urandom_range(255), 0, '0);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 65) begin
                row = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(20);
                col = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(20);
                hit = map_back(row, col, p, q, fx, fy, four);
                missing = 1'b0;
                if (hit) begin
                    // never read an entry that was never written; write it instead
                    for (int i = 0; i < (four ? 4 : 1) && !missing; i++) begin
                        addr = (p + i/2)*STORE_W + q + i%2;
                        if (!store_written[addr]) begin
                            missing = 1'b1;
                            send_request(imbr_pkg::ACT_WRITE, addr / STORE_W, addr % STORE_W,
                                         $urandom_range(255), $urandom_range(255),
                                         $urandom_range(255), 0, '0);
                        end
                    end
                end
                if (!missing) send_request(imbr_pkg::ACT_SAMPLE, row, col,
                                           $urandom_range(255), $urandom_range(255),
                                           $urandom_range(255), 0, '0);
            end else if ($urandom_range(99) < 80) begin
                send_request(imbr_pkg::ACT_WRITE, $urandom_range(20), $urandom_range(20),
                             $urandom_range(255), $urandom_range(255), $urandom_range(255),
                             0, '0);
            end else begin
                send_request(imbr_pkg::ACT_WRITE, $urandom_range(1023), $urandom_range(1023),
                             $urandom_range(255), $urandom_range(255), $urandom_range(255),
                             0, '0);
            end
        end
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 66; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 66; end
            default: begin gap_pct = 12; stall_pct = 12; end
        endcase
    endtask

    initial begin
        pixel_result_t typed_res;
        src_width = imbr_pkg::SIZE_RST;
        src_height = imbr_pkg::SIZE_RST;
        cx_col = imbr_pkg::COEF_ONE;
        cx_row = imbr_pkg::COEF_ZERO;
        cy_col = imbr_pkg::COEF_ZERO;
        cy_row = imbr_pkg::COEF_ONE;
        fill_shadow = imbr_pkg::FILL_RST;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table under reset settings
        foreach (directed_rows[i]) begin
            typed_res = '{directed_rows[i].exp_red[7:0], directed_rows[i].exp_green[7:0],
                          directed_rows[i].exp_blue[7:0], directed_rows[i].exp_in_range};
            send_request(directed_rows[i].action, directed_rows[i].row, directed_rows[i].col,
                         directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                         directed_rows[i].typed, typed_res);
        end
        drain();

        // Half scale, then long hold-off while requests keep coming
        set_idling(0);
        load_settings(8, 8, 2048, 0, 0, 2048, 0);
        hold_start = 1'b1;
        random_traffic(72);
        drain();

        // Rotation, width clamped up to one, height clamped down
        set_idling(1);
        load_settings(0, 511, 3547, -2048, 2048, 3547, 128);
        random_traffic(72);
        drain();

        // Coefficient extremes over the full store
        set_idling(2);
        load_settings(256, 256, 32767, -32768, -32768, 32767, 255);
        random_traffic(72);
        drain();

        // Mixed scale and shear
        set_idling(3);
        load_settings(12, 10, 3072, 1000, -700, 2900, 77);
        random_traffic(72);
        drain();

        // Random settings; an unused index must change nothing
        set_idling(0);
        load_settings($urandom_range(1, 16), $urandom_range(1, 16),
                      $urandom_range(12000) - 6000, $urandom_range(12000) - 6000,
                      $urandom_range(12000) - 6000, $urandom_range(12000) - 6000,
                      $urandom_range(255));
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        set_idling(3);
        random_traffic(72);
        drain();

        if (pending_pixels.size() != 0) begin
            $error("%0d results never arrived", pending_pixels.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("inverse_map_bilinear_resampler_top regression: pass");
        end else begin
            $display("inverse_map_bilinear_resampler_top regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/imbr_pkg.sv
rtl/inverse_map_bilinear_resampler_top.sv
rtl/imbr_checker.sv
tb/inverse_map_bilinear_resampler_top_tb.sv
